// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the line rasterizer.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the trigger.
`define ASSERT_SAME(lbl, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
    else $error("assertion failed");

// Check that the consequent holds in the cycle after the trigger.
`define ASSERT_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/brl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package brl_pkg;

  localparam int unsigned CoordW = 6;
  localparam int unsigned DecW   = 9;

  typedef logic [CoordW-1:0]       coord_t;
  typedef logic signed [DecW-1:0]  dec_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN
  } brl_state_t;

  // Request to the shared decision unit.
  typedef struct packed {
    dec_t a;
    dec_t b_take;
    dec_t b_skip;
    logic take_en;
    logic strict;
  } dec_req_t;

  typedef struct packed {
    dec_t sum;
    logic take;
  } dec_rsp_t;

  // Saturate a coordinate to the last grid index.
  function automatic coord_t clamp_coord(input coord_t v, input coord_t max_c);
    clamp_coord = (v > max_c) ? max_c : v;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/brl_dec_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Shared decision adder: test the decision, then add the chosen increment.
module brl_dec_unit (
  input  wire brl_pkg::dec_req_t req,
  output brl_pkg::dec_rsp_t      rsp
);

  logic          take;
  brl_pkg::dec_t addend;

  always_comb begin
    take   = req.strict ? (req.a > 0) : (req.a >= 0);
    addend = (req.take_en && take) ? req.b_take : req.b_skip;
    rsp.take = take;
    rsp.sum  = req.a + addend;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bresenham_line_rasterizer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Bresenham line rasterizer.
// Input channel (in_valid / in_ready): one line command per transfer, start and
// end grid coordinates. Coordinates at or above GRID_SIZE saturate to the last
// grid index.
// Output channel (out_valid / out_ready): one grid cell per transfer, from start
// to end, both endpoints included; out_last_pixel marks the end cell. A line of
// major length n gives n+1 cells; a zero-length line gives one cell.
// Timing: a command is taken in the idle state, a setup state follows, then
// one cell leaves per cycle while the receiver takes them. The first cell
// goes from the setup state to the run state and into the output register.
// The single decision adder serves setup and every step.
// in_ready is high only while idle; it rises in the cycle after the last cell
// is loaded into the output register, so the next command may enter while the
// last cell still waits.
// Receiver stall: the output register holds its cell and the walk pauses.
// Reset (rst_n low, synchronous): the sequencer returns to idle and the output
// register empties.
`include "assert_macros.svh"

module bresenham_line_rasterizer_core #(
  parameter int unsigned GRID_SIZE = 64
) (
  input  wire  logic                    clk,
  input  wire  logic                    rst_n,
  input  wire  logic                    in_valid,
  output       logic                    in_ready,
  input  wire  logic [5:0]              in_start_x,
  input  wire  logic [5:0]              in_start_y,
  input  wire  logic [5:0]              in_end_x,
  input  wire  logic [5:0]              in_end_y,
  output       logic                    out_valid,
  input  wire  logic                    out_ready,
  output       logic [5:0]              out_pixel_x,
  output       logic [5:0]              out_pixel_y,
  output       logic                    out_last_pixel
);

  localparam brl_pkg::coord_t MaxCoord = brl_pkg::coord_t'(GRID_SIZE - 1);
  localparam int unsigned     CW       = brl_pkg::CoordW;

  brl_pkg::brl_state_t state_r, state_nxt;

  brl_pkg::coord_t x0_r, y0_r, x1_r, y1_r;
  brl_pkg::coord_t x0_nxt, y0_nxt, x1_nxt, y1_nxt;
  brl_pkg::coord_t x_r, y_r, x_nxt, y_nxt;
  brl_pkg::coord_t n_r, n_nxt, idx_r, idx_nxt;
  brl_pkg::dec_t   p_r, p_nxt, inc_take_r, inc_take_nxt, inc_skip_r, inc_skip_nxt;
  logic            steep_r, steep_nxt, sx_neg_r, sx_neg_nxt, sy_neg_r, sy_neg_nxt;

  logic            out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  brl_pkg::coord_t out_x_r, out_x_nxt, out_y_r, out_y_nxt;

  brl_pkg::dec_req_t dec_req;
  brl_pkg::dec_rsp_t dec_rsp;

  logic                 slot_free;
  logic                 emit;
  logic signed [CW:0]   dx, dy;
  brl_pkg::coord_t      adx, ady, major, minor;
  logic                 steep_w;

  brl_dec_unit u_dec (
    .req (dec_req),
    .rsp (dec_rsp)
  );

  // Line geometry from the captured endpoints, used in the setup cycle.
  always_comb begin
    dx      = $signed({1'b0, x1_r}) - $signed({1'b0, x0_r});
    dy      = $signed({1'b0, y1_r}) - $signed({1'b0, y0_r});
    adx     = dx[CW] ? CW'(-dx) : dx[CW-1:0];
    ady     = dy[CW] ? CW'(-dy) : dy[CW-1:0];
    steep_w = ady > adx;
    major   = steep_w ? ady : adx;
    minor   = steep_w ? adx : ady;
  end

  assign slot_free = !out_valid_r || out_ready;

  // Sequencer: next state, walker update and output register loading.
  always_comb begin
    state_nxt     = state_r;
    x0_nxt        = x0_r;
    y0_nxt        = y0_r;
    x1_nxt        = x1_r;
    y1_nxt        = y1_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    p_nxt         = p_r;
    inc_take_nxt  = inc_take_r;
    inc_skip_nxt  = inc_skip_r;
    steep_nxt     = steep_r;
    sx_neg_nxt    = sx_neg_r;
    sy_neg_nxt    = sy_neg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_last_nxt  = out_last_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    in_ready      = 1'b0;
    emit          = 1'b0;

    // Default request: one walk step.
    dec_req.a       = p_r;
    dec_req.b_take  = inc_take_r;
    dec_req.b_skip  = inc_skip_r;
    dec_req.take_en = 1'b1;
    dec_req.strict  = steep_r;

    case (state_r)
      brl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          x0_nxt    = brl_pkg::clamp_coord(in_start_x, MaxCoord);
          y0_nxt    = brl_pkg::clamp_coord(in_start_y, MaxCoord);
          x1_nxt    = brl_pkg::clamp_coord(in_end_x, MaxCoord);
          y1_nxt    = brl_pkg::clamp_coord(in_end_y, MaxCoord);
          state_nxt = brl_pkg::ST_SETUP;
        end
      end
      brl_pkg::ST_SETUP: begin
        // Use the shared adder for the initial decision 2*minor - major.
        dec_req.a       = brl_pkg::dec_t'({minor, 1'b0});
        dec_req.b_take  = -brl_pkg::dec_t'(major);
        dec_req.b_skip  = -brl_pkg::dec_t'(major);
        dec_req.take_en = 1'b0;
        dec_req.strict  = 1'b0;
        p_nxt        = dec_rsp.sum;
        inc_skip_nxt = brl_pkg::dec_t'({minor, 1'b0});
        inc_take_nxt = brl_pkg::dec_t'({minor, 1'b0}) - brl_pkg::dec_t'({major, 1'b0});
        n_nxt        = major;
        steep_nxt    = steep_w;
        sx_neg_nxt   = dx[CW];
        sy_neg_nxt   = dy[CW];
        x_nxt        = x0_r;
        y_nxt        = y0_r;
        idx_nxt      = '0;
        state_nxt    = brl_pkg::ST_RUN;
      end
      brl_pkg::ST_RUN: begin
        if (slot_free) begin
          emit          = 1'b1;
          out_valid_nxt = 1'b1;
          if (idx_r == '0) begin
            out_x_nxt    = x_r;
            out_y_nxt    = y_r;
            out_last_nxt = (n_r == '0);
            idx_nxt      = idx_r + 1'b1;
            if (n_r == '0) begin
              state_nxt = brl_pkg::ST_IDLE;
            end
          end else if (idx_r == n_r) begin
            // End cell exactly as commanded.
            out_x_nxt    = x1_r;
            out_y_nxt    = y1_r;
            out_last_nxt = 1'b1;
            state_nxt    = brl_pkg::ST_IDLE;
          end else begin
            // Advance along the major axis; take the minor step on the decision.
            x_nxt = x_r;
            y_nxt = y_r;
            if (steep_r || dec_rsp.take) begin
              y_nxt = sy_neg_r ? y_r - 1'b1 : y_r + 1'b1;
            end
            if (!steep_r || dec_rsp.take) begin
              x_nxt = sx_neg_r ? x_r - 1'b1 : x_r + 1'b1;
            end
            p_nxt        = dec_rsp.sum;
            out_x_nxt    = x_nxt;
            out_y_nxt    = y_nxt;
            out_last_nxt = 1'b0;
            idx_nxt      = idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = brl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= brl_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and walker registers need no reset.
  always_ff @(posedge clk) begin
    x0_r       <= x0_nxt;
    y0_r       <= y0_nxt;
    x1_r       <= x1_nxt;
    y1_r       <= y1_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    n_r        <= n_nxt;
    idx_r      <= idx_nxt;
    p_r        <= p_nxt;
    inc_take_r <= inc_take_nxt;
    inc_skip_r <= inc_skip_nxt;
    steep_r    <= steep_nxt;
    sx_neg_r   <= sx_neg_nxt;
    sy_neg_r   <= sy_neg_nxt;
    out_last_r <= out_last_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_x    = out_x_r;
  assign out_pixel_y    = out_y_r;
  assign out_last_pixel = out_last_r;

  // Walk index never passes the major length.
  `ASSERT_SAME(a_idx_bound, state_r == brl_pkg::ST_RUN, idx_r <= n_r)
  // Loading the last cell ends the walk.
  `ASSERT_NEXT(a_last_ends, emit && out_last_nxt, state_r == brl_pkg::ST_IDLE)
  // The first cell of a line is its start point.
  `ASSERT_NEXT(a_first_cell, emit && idx_r == '0,
               out_valid && out_pixel_x == x0_r && out_pixel_y == y0_r)

endmodule

`default_nettype wire

// ===== tb/bresenham_line_rasterizer_core_tb.sv =====
`timescale 1ns / 1ps

module bresenham_line_rasterizer_core_tb;

  localparam int GRID = 64;
  // Cycles without any transfer before the run is declared hung.
  localparam int HANG_LIMIT = 1000;
  localparam int RANDOM_LINES = 126;

  typedef struct {
    brl_pkg::coord_t x;
    brl_pkg::coord_t y;
    logic            last;
  } cell_t;

  // Predicts the cells of every accepted line and checks the emitted ones in order.
  class line_scoreboard;
    cell_t cells_due[$];
    int errors;
    int lines_seen;
    int steep_lines;
    int point_lines;
    int cells_seen;

    function new();
      errors = 0;
      lines_seen = 0;
      steep_lines = 0;
      point_lines = 0;
      cells_seen = 0;
    endfunction

    function int pending();
      return cells_due.size();
    endfunction

    local function int saturate(input brl_pkg::coord_t v);
      return (int'(v) > GRID - 1) ? GRID - 1 : int'(v);
    endfunction

    local function void push_cell(input int x, input int y, input logic last);
      cell_t c;
      c.x = brl_pkg::coord_t'(x);
      c.y = brl_pkg::coord_t'(y);
      c.last = last;
      cells_due.push_back(c);
    endfunction

    // Walk the major axis and pick minor steps from the decision term.
    function void note_line(input brl_pkg::coord_t sx_in, input brl_pkg::coord_t sy_in,
                            input brl_pkg::coord_t ex_in, input brl_pkg::coord_t ey_in);
      int x0, y0, x1, y1;
      int dx, dy, step_x, step_y, adx, ady;
      int major_len, x, y, decision, k;
      bit steep;
      x0 = saturate(sx_in);
      y0 = saturate(sy_in);
      x1 = saturate(ex_in);
      y1 = saturate(ey_in);
      dx = x1 - x0;
      dy = y1 - y0;
      step_x = (dx < 0) ? -1 : 1;
      step_y = (dy < 0) ? -1 : 1;
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      steep = ady > adx;
      major_len = steep ? ady : adx;
      x = x0;
      y = y0;
      lines_seen++;
      if (steep) steep_lines++;
      push_cell(x, y, major_len == 0);
      if (major_len == 0) begin
        point_lines++;
        return;
      end
      decision = steep ? (2 * adx - ady) : (2 * ady - adx);
      for (k = 1; k < major_len; k++) begin
        if (steep) begin
          y += step_y;
          // steep lines take the minor step only on a strictly positive term
          if (decision > 0) begin
            x += step_x;
            decision += 2 * adx - 2 * ady;
          end else begin
            decision += 2 * adx;
          end
        end else begin
          x += step_x;
          if (decision >= 0) begin
            y += step_y;
            decision += 2 * ady - 2 * adx;
          end else begin
            decision += 2 * ady;
          end
        end
        push_cell(x, y, 1'b0);
      end
      push_cell(x1, y1, 1'b1);
    endfunction

    function void check_cell(input brl_pkg::coord_t x, input brl_pkg::coord_t y,
                             input logic last);
      cell_t want;
      cells_seen++;
      if (cells_due.size() == 0) begin
        errors++;
        $display("%0t: cell expected none, got (%0d,%0d) last %0b", $time, x, y, last);
        return;
      end
      want = cells_due.pop_front();
      if (x !== want.x) begin
        errors++;
        $display("%0t: pixel_x expected %0d, got %0d", $time, want.x, x);
      end
      if (y !== want.y) begin
        errors++;
        $display("%0t: pixel_y expected %0d, got %0d", $time, want.y, y);
      end
      if (last !== want.last) begin
        errors++;
        $display("%0t: last_pixel expected %0b, got %0b", $time, want.last, last);
      end
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  brl_pkg::coord_t in_start_x = '0;
  brl_pkg::coord_t in_start_y = '0;
  brl_pkg::coord_t in_end_x = '0;
  brl_pkg::coord_t in_end_y = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  brl_pkg::coord_t out_pixel_x;
  brl_pkg::coord_t out_pixel_y;
  logic            out_last_pixel;

  line_scoreboard sb = new();
  // Set during stretches where neither side inserts idle cycles.
  bit no_idle = 1'b0;
  int idle_cycles = 0;

  bresenham_line_rasterizer_core #(
    .GRID_SIZE(GRID)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_start_x    (in_start_x),
    .in_start_y    (in_start_y),
    .in_end_x      (in_end_x),
    .in_end_y      (in_end_y),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_x   (out_pixel_x),
    .out_pixel_y   (out_pixel_y),
    .out_last_pixel(out_last_pixel)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hang detection: count cycles in which neither channel completes a transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= HANG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d cells still due",
                 $time, idle_cycles, sb.pending());
        $display("bresenham_line_rasterizer_core_tb: errors");
        $finish;
      end
    end
  end

  // Offer one line command after a random gap, hold it until the transfer.
  task automatic send_line(input int sx, input int sy, input int ex, input int ey);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_start_x <= brl_pkg::coord_t'(sx);
    in_start_y <= brl_pkg::coord_t'(sy);
    in_end_x   <= brl_pkg::coord_t'(ex);
    in_end_y   <= brl_pkg::coord_t'(ey);
    do @(posedge clk); while (!in_ready);
    sb.note_line(brl_pkg::coord_t'(sx), brl_pkg::coord_t'(sy),
                 brl_pkg::coord_t'(ex), brl_pkg::coord_t'(ey));
  endtask

  // Drop valid and hold off until every predicted cell has come out.
  task automatic drain_lines();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Random offset of up to eight cells, kept on the grid.
  function automatic int near(input int c);
    int r;
    int v;
    r = $urandom_range(0, 16);
    v = c + r - 8;
    if (v < 0) v = 0;
    if (v > GRID - 1) v = GRID - 1;
    return v;
  endfunction

  // Receiver: random stall before each cell, then take it and check it.
  initial begin : receiver
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_cell(out_pixel_x, out_pixel_y, out_last_pixel);
    end
  end

  initial begin : sender
    int i;
    int kind;
    int sx, sy, ex, ey, d;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Points: start equal to end gives one cell flagged last.
    send_line(0, 0, 0, 0);
    send_line(63, 63, 63, 63);
    // Full-grid diagonals and axis lines, both directions.
    send_line(0, 0, 63, 63);
    send_line(63, 63, 0, 0);
    send_line(63, 0, 0, 63);
    send_line(0, 63, 63, 0);
    send_line(0, 5, 63, 5);
    send_line(63, 40, 0, 40);
    send_line(7, 0, 7, 63);
    send_line(50, 63, 50, 0);
    // Ties on a zero decision: shallow steps, steep does not.
    send_line(10, 10, 12, 11);
    send_line(12, 11, 10, 10);
    send_line(10, 10, 11, 12);
    send_line(11, 12, 10, 10);
    // One line per octant.
    send_line(20, 20, 30, 24);
    send_line(20, 20, 24, 30);
    send_line(20, 20, 16, 30);
    send_line(20, 20, 10, 24);
    send_line(20, 20, 10, 16);
    send_line(20, 20, 16, 10);
    send_line(20, 20, 24, 10);
    send_line(20, 20, 30, 16);
    // Single-step lines.
    send_line(0, 0, 1, 0);
    send_line(63, 63, 62, 62);
    drain_lines();

    for (i = 0; i < RANDOM_LINES; i++) begin
      no_idle = (i >= 60 && i < 85);
      kind = $urandom_range(0, 9);
      sx = $urandom_range(0, 63);
      sy = $urandom_range(0, 63);
      if (kind < 6) begin
        // short lines keep the run quick and hit every octant often
        ex = near(sx);
        ey = near(sy);
      end else if (kind < 9) begin
        ex = $urandom_range(0, 63);
        ey = $urandom_range(0, 63);
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            ex = sx;
            ey = sy;
          end
          1: begin
            ex = sx;
            ey = $urandom_range(0, 63);
          end
          2: begin
            ex = $urandom_range(0, 63);
            ey = sy;
          end
          default: begin
            ex = near(sx);
            d = ex - sx;
            ey = (sy + d >= 0 && sy + d <= GRID - 1) ? sy + d : sy - d;
          end
        endcase
      end
      send_line(sx, sy, ex, ey);
      if (i == 100) drain_lines();
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    // Leave room for any stray cell after the last expected one.
    repeat (GRID + 8) @(posedge clk);

    $display("covered %0d line commands (%0d steep, %0d single-cell), %0d cells checked",
             sb.lines_seen, sb.steep_lines, sb.point_lines, sb.cells_seen);
    if (sb.errors == 0) begin
      $display("bresenham_line_rasterizer_core_tb: clean");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("bresenham_line_rasterizer_core_tb: errors");
    end
    $finish;
  end

endmodule

// ===== bresenham_line_rasterizer_core.f =====
+incdir+hw/rtl
hw/rtl/brl_pkg.sv
hw/rtl/brl_dec_unit.sv
hw/rtl/bresenham_line_rasterizer_core.sv
tb/bresenham_line_rasterizer_core_tb.sv
